### sv/rcadc_pkg.sv
// types and constants shared by the rc charge-time converter
package rcadc_pkg;

  localparam int unsigned PIN_COUNT = 8;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned CNT_W     = 4;
  localparam logic [CNT_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_DISCHARGE = 2'd1,
    PH_CHARGE    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [PIN_COUNT-1:0] pin_levels;
    logic [31:0]          now_us;
  } in_t;

  typedef struct packed {
    logic            discharge_drive;
    logic            capture_valid;
    logic [CH_W-1:0] channel;
    logic [31:0]     duration;
    logic            cycle_done;
    logic            last;
  } out_t;

  // one result slot travelling down the cell chain
  typedef struct packed {
    logic            vld;
    logic            cap;
    logic [CH_W-1:0] channel;
    logic            last;
  } slot_t;

  typedef struct packed {
    logic load;
    logic adv;
    logic arm;
    logic scan;
    logic clear;
  } cell_ctrl_t;

endpackage

### sv/rcadc_cell.sv
// one channel cell: pending flag, capture detect and one slot of the result chain
module rcadc_cell #(
  parameter int unsigned CH_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcadc_pkg::cell_ctrl_t ctrl_i,
  input  logic                 pin_i,
  input  logic                 in_use_i,
  input  logic                 above_hit_i,
  input  rcadc_pkg::slot_t     nb_slot_i,
  output logic                 hit_o,
  output logic                 any_hit_o,
  output logic                 pend_o,
  output rcadc_pkg::slot_t     slot_o
);
  import rcadc_pkg::*;

  logic  pend_q, pend_d;
  slot_t slot_q, slot_d;

  assign hit_o     = ctrl_i.scan & pin_i & pend_q & in_use_i;
  assign any_hit_o = hit_o | above_hit_i;
  assign pend_o    = pend_q;
  assign slot_o    = slot_q;

  always_comb begin
    pend_d = pend_q;
    priority if (ctrl_i.arm) begin
      pend_d = in_use_i;
    end else if (ctrl_i.clear || hit_o) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.load) begin
      slot_d = '0;
      if (hit_o) begin
        slot_d.vld     = 1'b1;
        slot_d.cap     = 1'b1;
        slot_d.channel = CH_W'(CH_IDX);
        slot_d.last    = ~above_hit_i;
      end else if ((CH_IDX == 0) && !above_hit_i) begin
        // no capture at all on this tick: a single status result
        slot_d.vld  = 1'b1;
        slot_d.last = 1'b1;
      end
    end else if (ctrl_i.adv) begin
      slot_d = nb_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      slot_q <= '0;
    end else begin
      pend_q <= pend_d;
      slot_q <= slot_d;
    end
  end

endmodule

### sv/rc_charge_time_multichannel_adc.sv
// top level of the multichannel rc charge-time converter
//
//   transfer   direction  handshake                 payload
//   in         in         in_valid_i / in_stall_o   in_data_i  (pin levels, time)
//   out        out        out_valid_o / out_stall_i out_data_o (one result)
//   cfg        in         cfg_valid_i / cfg_ready_o cfg_data_i (channels in use)
//
// a tick is evaluated in the cycle it is taken and loads the cell chain, one
// slot per channel; the chain shifts one slot a cycle into the output register
// unless out_stall_i holds it; a tick's highest capture sets how long it lasts.
// the next tick is taken in the cycle the last slot leaves the chain.
// out_stall_i holds the chain and the output register; nothing is dropped.
// reset: idle phase, nothing pending, channels in use 8.
module rc_charge_time_multichannel_adc #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rcadc_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rcadc_pkg::out_t                 out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcadc_pkg::CNT_W-1:0]     cfg_data_i
);
  import rcadc_pkg::*;

  localparam int unsigned NCELL = (MAX_CHANNELS < PIN_COUNT) ? MAX_CHANNELS : PIN_COUNT;
  localparam logic [CNT_W-1:0] NCELL_N = CNT_W'(NCELL);

  logic [CNT_W-1:0] cfg_q;
  phase_e           phase_q, phase_d;
  logic [31:0]      start_q;
  logic [CNT_W-1:0] meas_q, meas_d;
  logic             drive_q, done_q;
  logic [31:0]      dur_q;
  logic             out_vld_q;
  out_t             out_q;

  logic             acc, load_out, adv, busy, quiet, done_w, arm_w, scan_w;
  logic [CNT_W-1:0] n_raw, n_act, cnt, cnt_new;
  logic [PIN_COUNT-1:0] in_use;
  cell_ctrl_t       ctrl;
  slot_t            slot_w [NCELL+1];
  logic [NCELL:0]   above_w;
  logic [NCELL-1:0] hits, pend, vlds, lasts;

  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i & ~in_stall_o;
  // a new tick may load as the last slot of the previous one leaves
  assign in_stall_o  = ((vlds >> 1) != '0) | (vlds[0] & ~load_out);
  assign busy        = |vlds;
  assign load_out    = ~out_vld_q | ~out_stall_i;
  assign adv         = ~slot_w[0].vld | load_out;

  // active channel count, clamped to 1 .. cells
  assign n_raw = (cfg_q == '0) ? CNT_W'(1) : cfg_q;
  assign n_act = (n_raw > NCELL_N) ? NCELL_N : n_raw;

  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      in_use[i] = CNT_W'(i) < n_act;
    end
  end

  assign quiet  = (in_data_i.pin_levels & in_use) == '0;
  assign arm_w  = acc && (phase_q == PH_DISCHARGE) && quiet;
  assign scan_w = acc && (phase_q == PH_CHARGE);

  always_comb begin
    cnt = '0;
    for (int i = 0; i < NCELL; i++) begin
      cnt = cnt + CNT_W'(hits[i]);
    end
  end

  assign cnt_new = meas_q + cnt;
  assign done_w  = scan_w && (cnt_new >= n_act);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      unique case (phase_q)
        PH_DISCHARGE: if (quiet)  phase_d = PH_CHARGE;
        PH_CHARGE:    if (done_w) phase_d = PH_IDLE;
        default:      phase_d = PH_DISCHARGE;
      endcase
    end
  end

  // cell controls and capture count
  always_comb begin
    ctrl.load  = acc;
    ctrl.adv   = adv;
    ctrl.arm   = arm_w;
    ctrl.scan  = scan_w;
    ctrl.clear = done_w;
    meas_d     = meas_q;
    if (arm_w) begin
      meas_d = '0;
    end else if (scan_w) begin
      meas_d = done_w ? '0 : cnt_new;
    end
  end

  assign slot_w[NCELL]  = '0;
  assign above_w[NCELL] = 1'b0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rcadc_cell #(
      .CH_IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pin_i      (in_data_i.pin_levels[g]),
      .in_use_i   (in_use[g]),
      .above_hit_i(above_w[g+1]),
      .nb_slot_i  (slot_w[g+1]),
      .hit_o      (hits[g]),
      .any_hit_o  (above_w[g]),
      .pend_o     (pend[g]),
      .slot_o     (slot_w[g])
    );
    assign vlds[g]  = slot_w[g].vld;
    assign lasts[g] = slot_w[g].vld & slot_w[g].last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CFG_RESET;
      phase_q   <= PH_IDLE;
      start_q   <= '0;
      meas_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      meas_q  <= meas_d;
      if (arm_w) begin
        start_q <= in_data_i.now_us;
      end
      if (load_out) begin
        out_vld_q <= slot_w[0].vld;
      end
    end
  end

  // per-tick fields shared by all results of the tick, and the output result register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      drive_q <= phase_d == PH_DISCHARGE;
      done_q  <= done_w;
      dur_q   <= in_data_i.now_us - start_q;
    end
    if (load_out && slot_w[0].vld) begin
      out_q.discharge_drive <= drive_q;
      out_q.capture_valid   <= slot_w[0].cap;
      out_q.channel         <= slot_w[0].channel;
      out_q.duration        <= slot_w[0].cap ? dur_q : '0;
      out_q.cycle_done      <= done_q;
      out_q.last            <= slot_w[0].last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy)
    else $error("accepted tick left the cell chain empty");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lasts))
    else $error("more than one final result in the cell chain");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_CHARGE) |-> (pend == '0))
    else $error("channel pending outside the charge phase");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.capture_valid) |-> (out_q.duration == '0 && out_q.last))
    else $error("status result carries capture data");
`endif

endmodule

### tb/sv/rc_charge_time_multichannel_adc_test.sv
// self-checking testbench for the multichannel rc charge-time converter
module rc_charge_time_multichannel_adc_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcadc_pkg::*;

  localparam int unsigned MAX_CH       = 8;
  localparam int unsigned RANDOM_TICKS = 280;
  localparam int unsigned CALM_TICKS   = 40;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [3:0] cfg;
    in_t        tick;
    logic       typed;
    out_t       want;
  } stim_row_t;

  // status results that need no arithmetic to read off
  localparam out_t DISCHARGING = '{1'b1, 1'b0, 3'd0, 32'd0, 1'b0, 1'b1};
  localparam out_t CHARGING    = '{1'b0, 1'b0, 3'd0, 32'd0, 1'b0, 1'b1};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i  = '0;

  rc_charge_time_multichannel_adc #(.MAX_CHANNELS(MAX_CH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the converter state
  phase_e     ph         = PH_IDLE;
  logic [31:0] start_us  = '0;
  logic [7:0] armed      = '0;
  logic [3:0] captured   = '0;
  logic [3:0] ch_setting = CFG_RESET;

  out_t tick_results [$];
  out_t awaited [$];
  int   errors    = 0;
  bit   calm      = 1'b0;
  bit   hold_req  = 1'b0;
  bit   hold_done = 1'b0;

  stim_row_t directed_rows [$] = '{
    '{ROW_TICK, 4'd0, '{8'hFF, 32'h0000_0000}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'h01, 32'h0000_0005}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'h80, 32'h0000_0006}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'h00, 32'hFFFF_FFF0}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'h00, 32'hFFFF_FFFF}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'h81, 32'h0000_0005}, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'h81, 32'h0000_000A}, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'h7E, 32'h8000_0000}, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'hFF, 32'h0000_1234}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'h00, 32'h0000_0064}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'hFF, 32'h0000_0064}, 1'b0, '0},
    '{ROW_CFG,  4'd0, '0, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'hFE, 32'h0000_0007}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'hFE, 32'h0000_0008}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'hFE, 32'h0000_0009}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'h01, 32'h0000_0009}, 1'b1,
      '{1'b0, 1'b1, 3'd0, 32'd1, 1'b1, 1'b1}},
    '{ROW_CFG,  4'd15, '0, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'h55, 32'h0000_00C8}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'h00, 32'h0000_00C9}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'hAA, 32'h0000_012C}, 1'b0, '0},
    // count lowered while half the channels are still pending
    '{ROW_CFG,  4'd3, '0, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'h01, 32'h0000_0136}, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'h00, 32'h0000_0190}, 1'b1, DISCHARGING},
    '{ROW_TICK, 4'd0, '{8'hF8, 32'h0000_019A}, 1'b1, CHARGING},
    '{ROW_TICK, 4'd0, '{8'h02, 32'h0000_01A4}, 1'b1,
      '{1'b0, 1'b1, 3'd1, 32'd10, 1'b0, 1'b1}},
    // cycle ends on a tick that captures nothing
    '{ROW_CFG,  4'd1, '0, 1'b0, '0},
    '{ROW_TICK, 4'd0, '{8'h00, 32'h0000_01AE}, 1'b1,
      '{1'b0, 1'b0, 3'd0, 32'd0, 1'b1, 1'b1}},
    '{ROW_CFG,  4'd8, '0, 1'b0, '0}
  };

  function automatic int unsigned active_count();
    int unsigned n;
    n = ch_setting;
    if (n < 1) n = 1;
    if (n > MAX_CH) n = MAX_CH;
    if (n > PIN_COUNT) n = PIN_COUNT;
    return n;
  endfunction

  function automatic logic [7:0] in_use_mask();
    logic [8:0] m;
    m = (9'd1 << active_count()) - 9'd1;
    return m[7:0];
  endfunction

  function automatic void convert_tick(input in_t t);
    int unsigned n;
    logic [7:0] mask;
    logic done;
    out_t r;
    n = active_count();
    mask = in_use_mask();
    done = 1'b0;
    tick_results.delete();
    case (ph)
      PH_DISCHARGE: begin
        if ((t.pin_levels & mask) == '0) begin
          start_us = t.now_us;
          armed = mask;
          captured = '0;
          ph = PH_CHARGE;
        end
      end
      PH_CHARGE: begin
        for (int i = 0; i < n; i++) begin
          if (t.pin_levels[i] && armed[i]) begin
            r = '0;
            r.capture_valid = 1'b1;
            r.channel = CH_W'(i);
            r.duration = t.now_us - start_us;
            tick_results.push_back(r);
            armed[i] = 1'b0;
            captured = captured + 4'd1;
          end
        end
        if (captured >= n) begin
          done = 1'b1;
          captured = '0;
          armed = '0;
          ph = PH_IDLE;
        end
      end
      default: ph = PH_DISCHARGE;
    endcase
    if (tick_results.size() == 0) begin
      r = '0;
      tick_results.push_back(r);
    end
    foreach (tick_results[k]) begin
      tick_results[k].discharge_drive = (ph == PH_DISCHARGE);
      tick_results[k].cycle_done = done;
      tick_results[k].last = (k == tick_results.size() - 1);
    end
  endfunction

  task automatic send_tick(input in_t t, input logic typed, input out_t want);
    in_data_i <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    convert_tick(t);
    if (typed) begin
      awaited.push_back(want);
    end else begin
      foreach (tick_results[k]) awaited.push_back(tick_results[k]);
    end
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // wait for every result, then give the chain time to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_channels(input logic [3:0] v);
    settle();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ch_setting = v;
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin : watch_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, out_data_o);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (out_data_o.discharge_drive !== want.discharge_drive)
          report("discharge_drive", want.discharge_drive, out_data_o.discharge_drive);
        if (out_data_o.capture_valid !== want.capture_valid)
          report("capture_valid", want.capture_valid, out_data_o.capture_valid);
        if (out_data_o.channel !== want.channel)
          report("channel", want.channel, out_data_o.channel);
        if (out_data_o.duration !== want.duration)
          report("duration", want.duration, out_data_o.duration);
        if (out_data_o.cycle_done !== want.cycle_done)
          report("cycle_done", want.cycle_done, out_data_o.cycle_done);
        if (out_data_o.last !== want.last)
          report("last", want.last, out_data_o.last);
      end
    end
  end

  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // long hold-off so the chain backs up into the input
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    in_t        t;
    logic [7:0] mask;
    logic [7:0] charged;
    logic [3:0] pick;
    logic [31:0] cur_us;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        set_channels(directed_rows[r].cfg);
      end else begin
        send_tick(directed_rows[r].tick, directed_rows[r].typed, directed_rows[r].want);
        maybe_pause();
      end
    end

    hold_req = 1'b1;
    charged = '0;
    cur_us = 32'hFFFF_C000;
    for (int k = 0; k < RANDOM_TICKS; k++) begin
      if (k == RANDOM_TICKS - CALM_TICKS) calm = 1'b1;
      if ((ph == PH_IDLE) ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 99) == 0)) begin
        if (ph != PH_IDLE) begin
          // only lower the count mid-cycle, raising it would strand the cycle
          pick = 4'($urandom_range(0, active_count()));
        end else begin
          case ($urandom_range(0, 4))
            0: pick = 4'd0;
            1: pick = 4'd15;
            2: pick = 4'd1;
            3: pick = 4'd8;
            default: pick = 4'($urandom_range(0, 15));
          endcase
        end
        set_channels(pick);
      end
      mask = in_use_mask();
      if (ph != PH_CHARGE) charged = '0;
      case (ph)
        PH_DISCHARGE: begin
          if ($urandom_range(0, 2) != 0) t.pin_levels = 8'($urandom) & ~mask;
          else t.pin_levels = 8'($urandom);
        end
        PH_CHARGE: begin
          // capacitors charge up a few at a time, stray pins above the count
          charged = charged | (8'($urandom) & 8'($urandom));
          if ($urandom_range(0, 7) == 0) t.pin_levels = 8'($urandom);
          else t.pin_levels = (charged & mask) | (8'($urandom) & ~mask);
        end
        default: t.pin_levels = 8'($urandom);
      endcase
      if ($urandom_range(0, 24) == 0) cur_us = $urandom;
      else cur_us = cur_us + $urandom_range(0, 300);
      t.now_us = cur_us;
      send_tick(t, 1'b0, '0);
      maybe_pause();
    end

    settle();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
sv/rcadc_pkg.sv
sv/rcadc_cell.sv
sv/rc_charge_time_multichannel_adc.sv
tb/sv/rc_charge_time_multichannel_adc_test.sv
